FILE: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true on a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

FILE: sv/bfz_pkg.sv
package bfz_pkg;

	// field widths
	localparam int TYPE_W = 3;
	localparam int IDX_W  = 12;
	localparam int LEN_W  = 13;
	localparam int FIDX_W = 13;

	// absolute bit positions inside a search, with headroom for one word step
	localparam int POS_W = 14;

	// reciprocal scaling for splitting a bit index into word and offset
	localparam int RECIP_K = 20;

	// request codes
	localparam logic [TYPE_W-1:0] OP_TEST = 3'd0;
	localparam logic [TYPE_W-1:0] OP_SET  = 3'd1;
	localparam logic [TYPE_W-1:0] OP_CLR  = 3'd2;
	localparam logic [TYPE_W-1:0] OP_TAS  = 3'd3;
	localparam logic [TYPE_W-1:0] OP_TAC  = 3'd4;
	localparam logic [TYPE_W-1:0] OP_FIND = 3'd5;

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_SPLIT,
		ST_EXEC,
		ST_DONE
	} state_t;

endpackage

FILE: sv/bitmap_store_with_first_zero_search.sv
// bit requests: split into word and offset, then the word is read and updated in exec
// searches: after the split state the walk visits the words in turn, one word a cycle
// the loop over words is the single find-first-zero unit fed by the bitmap ram read port
// one request in flight; in_ready is low from transfer until the result transfer
// arst_n clears the sequencer; the ram is then wiped, one word a cycle, across all
// (MAP_BITS + WORD_BITS - 1) / WORD_BITS words before in_ready first rises
module bitmap_store_with_first_zero_search #(
	parameter int MAP_BITS  = 4096,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [11:0] bit_index,
	input  logic [12:0] search_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        old_bit,
	output logic [12:0] found_index,
	output logic        found
);

	localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int SW   = $clog2(WORD_BITS);
	localparam int NW   = $clog2(MAP_BITS + 1);
	localparam int CW   = ((NW > bfz_pkg::LEN_W) ? NW : bfz_pkg::LEN_W) + 1;
	localparam int QXW  = (AW > bfz_pkg::IDX_W) ? AW : bfz_pkg::IDX_W;
	localparam int MW   = bfz_pkg::RECIP_K + 1;
	localparam int PRW  = bfz_pkg::IDX_W + MW;
	localparam int PW   = bfz_pkg::POS_W;
	localparam logic [MW-1:0] RECIP =
		MW'((2 ** bfz_pkg::RECIP_K + WORD_BITS - 1) / WORD_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);
	localparam logic [PW-1:0] WORD_STEP = PW'(WORD_BITS);

	bfz_pkg::state_t state_q, state_d;

	// request held for the duration of the operation
	logic [bfz_pkg::TYPE_W-1:0] type_q;
	logic [bfz_pkg::IDX_W-1:0]  idx_q;
	logic [bfz_pkg::LEN_W-1:0]  len_q;
	logic                       in_range_q;
	logic [PRW-1:0]             prod_q;

	// walk position
	logic [AW-1:0] wipe_q;
	logic [AW-1:0] word_q;
	logic [SW-1:0] off_q;
	logic [PW-1:0] base_q;
	logic [PW-1:0] end_q;

	// result
	logic                       old_q;
	logic [bfz_pkg::FIDX_W-1:0] fidx_q;
	logic                       found_q;

	// ram ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// split of the held index into word and offset (reciprocal multiply)
	logic [bfz_pkg::IDX_W-1:0] quot;
	logic [QXW-1:0]            quot_x;
	logic [AW-1:0]             quot_addr;
	logic [PW-1:0]             word_base;
	logic [SW-1:0]             quot_off;

	// clamped search range
	logic [CW-1:0] start_c;
	logic [CW-1:0] avail_c;
	logic [CW-1:0] len_c;
	logic [CW-1:0] lenk_c;
	logic [PW-1:0] end_c;

	// find-first-zero unit over one word
	logic [PW-1:0]        lim;
	logic [WORD_BITS-1:0] cand;
	logic                 hit;
	logic [SW-1:0]        hit_idx;
	logic                 last_word;

	// bit request on the fetched word
	logic                 is_find;
	logic                 is_bitop;
	logic                 do_set;
	logic                 do_clr;
	logic                 cur_bit;
	logic [WORD_BITS-1:0] mod_word;

	assign is_find  = (type_q == bfz_pkg::OP_FIND);
	assign is_bitop = (type_q == bfz_pkg::OP_TEST) || (type_q == bfz_pkg::OP_SET) ||
		(type_q == bfz_pkg::OP_CLR) || (type_q == bfz_pkg::OP_TAS) ||
		(type_q == bfz_pkg::OP_TAC);
	assign do_set = (type_q == bfz_pkg::OP_SET) || (type_q == bfz_pkg::OP_TAS);
	assign do_clr = (type_q == bfz_pkg::OP_CLR) || (type_q == bfz_pkg::OP_TAC);

	// quotient is exact for every 12-bit index at this reciprocal scaling
	assign quot      = bfz_pkg::IDX_W'(prod_q >> bfz_pkg::RECIP_K);
	assign quot_x    = QXW'(quot);
	assign quot_addr = quot_x[AW-1:0];
	assign word_base = PW'(PW'(quot) * WORD_STEP);
	assign quot_off  = SW'(PW'(idx_q) - word_base);

	// length clamped to the end of the map, empty when the start is off the map
	always_comb begin
		start_c = CW'(idx_q);
		avail_c = CW'(MAP_BITS) - start_c;
		len_c   = CW'(len_q);
		lenk_c  = (len_c > avail_c) ? avail_c : len_c;
		if (!in_range_q) begin
			lenk_c = '0;
		end
		end_c = PW'(start_c + lenk_c);
	end

	// candidates: zero bits at or after the start offset and below the end
	always_comb begin
		lim = end_q - base_q;
		for (int i = 0; i < WORD_BITS; i++) begin
			cand[i] = !ram_rdata[i] && (SW'(i) >= off_q) && (PW'(i) < lim);
		end
		hit     = |cand;
		hit_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				hit_idx = SW'(i);
			end
		end
		last_word = (base_q + WORD_STEP) >= end_q;
	end

	always_comb begin
		cur_bit  = ram_rdata[off_q];
		mod_word = ram_rdata;
		mod_word[off_q] = do_set;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfz_pkg::ST_WIPE: begin
				if (wipe_q == LAST_WORD) begin
					state_d = bfz_pkg::ST_IDLE;
				end
			end
			bfz_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bfz_pkg::ST_SPLIT;
				end
			end
			bfz_pkg::ST_SPLIT: begin
				if (is_find) begin
					state_d = (end_c != PW'(idx_q)) ? bfz_pkg::ST_EXEC : bfz_pkg::ST_DONE;
				end else if (is_bitop && in_range_q) begin
					state_d = bfz_pkg::ST_EXEC;
				end else begin
					state_d = bfz_pkg::ST_DONE;
				end
			end
			bfz_pkg::ST_EXEC: begin
				if (!is_find || hit || last_word) begin
					state_d = bfz_pkg::ST_DONE;
				end
			end
			bfz_pkg::ST_DONE: begin
				if (out_ready) begin
					state_d = bfz_pkg::ST_IDLE;
				end
			end
			default: state_d = bfz_pkg::ST_WIPE;
		endcase
	end

	// handshake and ram control
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = mod_word;
		ram_raddr = '0;
		case (state_q)
			bfz_pkg::ST_WIPE: begin
				ram_we    = 1'b1;
				ram_waddr = wipe_q;
				ram_wdata = '0;
			end
			bfz_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			bfz_pkg::ST_SPLIT: begin
				ram_raddr = quot_addr;
			end
			bfz_pkg::ST_EXEC: begin
				// prefetch the following word so the walk keeps one word a cycle
				ram_raddr = word_q + AW'(1);
				ram_we    = !is_find && (do_set || do_clr);
			end
			bfz_pkg::ST_DONE: begin
				out_valid = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfz_pkg::ST_WIPE;
			wipe_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bfz_pkg::ST_WIPE) begin
				wipe_q <= wipe_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bfz_pkg::ST_IDLE: begin
				if (in_valid) begin
					type_q     <= req_type;
					idx_q      <= bit_index;
					len_q      <= search_length;
					in_range_q <= CW'(bit_index) < CW'(MAP_BITS);
					prod_q     <= PRW'(bit_index) * PRW'(RECIP);
				end
			end
			bfz_pkg::ST_SPLIT: begin
				word_q  <= quot_addr;
				off_q   <= quot_off;
				base_q  <= word_base;
				end_q   <= end_c;
				old_q   <= 1'b0;
				found_q <= 1'b0;
				// a failed search answers the clamped end
				fidx_q  <= is_find ? bfz_pkg::FIDX_W'(end_c) : '0;
			end
			bfz_pkg::ST_EXEC: begin
				if (!is_find) begin
					old_q <= cur_bit;
				end else if (hit) begin
					found_q <= 1'b1;
					fidx_q  <= bfz_pkg::FIDX_W'(base_q + PW'(hit_idx));
				end else begin
					word_q <= word_q + AW'(1);
					off_q  <= '0;
					base_q <= base_q + WORD_STEP;
				end
			end
			default: ;
		endcase
	end

	assign old_bit     = old_q;
	assign found_index = fidx_q;
	assign found       = found_q;

	bfz_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

FILE: sv/bfz_ram.sv
module bfz_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/bfz_checker.sv
`include "assert_macros.svh"

module bfz_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        old_bit,
	input logic [12:0] found_index,
	input logic        found
);

	// a waiting result holds still
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(old_bit) && $stable(found_index) && $stable(found), "result changed while stalled")

	// one request at a time
	`ASSERT_NEVER(a_one_in_flight, clk, arst_n, in_ready && out_valid, "input open while a result waits")

	`ASSERT_CLK(a_busy_after_in, clk, arst_n, in_valid && in_ready |=> !in_ready, "input taken again right after a transfer")

	// a search never reports an old bit
	`ASSERT_CLK(a_found_no_old, clk, arst_n, out_valid && found |-> !old_bit, "search result carries an old bit")

endmodule

bind bitmap_store_with_first_zero_search bfz_checker u_bfz_checker (.*);

FILE: bench/bitmap_store_with_first_zero_search_tb.sv
module bitmap_store_with_first_zero_search_tb;

	// map geometry at the default parameters
	localparam int MAP_BITS  = 4096;
	localparam int WORD_W    = 32;
	localparam int MAP_WORDS = MAP_BITS / WORD_W;
	localparam int WORD_AW   = $clog2(MAP_WORDS);
	localparam int OFF_W     = $clog2(WORD_W);

	// request codes the block does not handle
	localparam logic [bfz_pkg::TYPE_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [bfz_pkg::TYPE_W-1:0] OP_RSVD7 = 3'd7;

	localparam int TOTAL_ITEMS  = 1850;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 200;   // longest search walks 128 words plus pipeline
	localparam int LONG_STALL   = 300;   // receiver hold-off, far longer than one request

	typedef struct packed {
		logic [bfz_pkg::TYPE_W-1:0] kind;
		logic [bfz_pkg::IDX_W-1:0]  idx;
		logic [bfz_pkg::LEN_W-1:0]  len;
	} request_t;

	typedef struct packed {
		logic                       old_bit;
		logic [bfz_pkg::FIDX_W-1:0] found_index;
		logic                       found;
	} answer_t;

	// one line of the directed table; typed rows carry a hand-written answer
	typedef struct packed {
		request_t req;
		logic     typed;
		answer_t  ans;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        req_type;
	logic [11:0]       bit_index;
	logic [12:0]       search_length;
	logic              out_valid;
	logic              out_ready;
	logic              old_bit;
	logic [12:0]       found_index;
	logic              found;

	// shadow copy of the allocation map, cleared like the block after reset
	logic [WORD_W-1:0] map_words [MAP_WORDS];

	answer_t           predicted_answers [$];
	row_t              directed_rows [$];

	int                error_count;
	int                cycle_count;
	int                sent_count;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                idle_phase;
	int                stall_asked;
	int                stall_done;

	// what the run went through
	int                bit_op_count;
	int                search_count;
	int                search_hits;
	int                full_word_searches;
	int                unused_count;

	bitmap_store_with_first_zero_search u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.bit_index     (bit_index),
		.search_length (search_length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.old_bit       (old_bit),
		.found_index   (found_index),
		.found         (found)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// apply one request to the shadow map and return the answer the block owes
	function automatic answer_t bitmap_apply(input request_t req);
		answer_t            ans;
		int unsigned        start;
		int unsigned        stop;
		int unsigned        pos;
		logic [WORD_AW-1:0] w;
		logic [OFF_W-1:0]   b;
		logic               hit;
		logic               crossed_full;
		ans = '0;
		start = 32'(req.idx);
		case (req.kind)
			bfz_pkg::OP_TEST, bfz_pkg::OP_SET, bfz_pkg::OP_CLR, bfz_pkg::OP_TAS,
			bfz_pkg::OP_TAC: begin
				w = WORD_AW'(start / WORD_W);
				b = OFF_W'(start % WORD_W);
				ans.old_bit = map_words[w][b];
				if (req.kind == bfz_pkg::OP_SET || req.kind == bfz_pkg::OP_TAS)
					map_words[w][b] = 1'b1;
				else if (req.kind == bfz_pkg::OP_CLR || req.kind == bfz_pkg::OP_TAC)
					map_words[w][b] = 1'b0;
				bit_op_count++;
			end
			bfz_pkg::OP_FIND: begin
				// length clamped at the end of the map
				stop = start + 32'(req.len);
				if (stop > MAP_BITS)
					stop = MAP_BITS;
				pos = start;
				hit = 1'b0;
				crossed_full = 1'b0;
				while (pos < stop && !hit) begin
					w = WORD_AW'(pos / WORD_W);
					b = OFF_W'(pos % WORD_W);
					if (b == '0 && stop - pos >= WORD_W && map_words[w] == '1)
						crossed_full = 1'b1;
					if (!map_words[w][b])
						hit = 1'b1;
					else
						pos++;
				end
				// on a miss pos has run up to the clamped end
				ans.found = hit;
				ans.found_index = pos[bfz_pkg::FIDX_W-1:0];
				search_count++;
				if (hit)
					search_hits++;
				if (crossed_full)
					full_word_searches++;
			end
			default: begin
				unused_count++;
			end
		endcase
		return ans;
	endfunction

	// words where most of the traffic lands, so that full words build up
	function automatic int unsigned hot_word();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return $urandom_range(7);
		else if (pick < 80)
			return $urandom_range(MAP_WORDS - 1, MAP_WORDS - 4);
		return $urandom_range(MAP_WORDS - 1);
	endfunction

	function automatic request_t random_request();
		request_t    req;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 12)
			req.kind = bfz_pkg::OP_TEST;
		else if (pick < 32)
			req.kind = bfz_pkg::OP_SET;
		else if (pick < 42)
			req.kind = bfz_pkg::OP_CLR;
		else if (pick < 54)
			req.kind = bfz_pkg::OP_TAS;
		else if (pick < 64)
			req.kind = bfz_pkg::OP_TAC;
		else if (pick < 94)
			req.kind = bfz_pkg::OP_FIND;
		else
			req.kind = ($urandom_range(1)) ? OP_RSVD6 : OP_RSVD7;
		// half the indexes in the hot words, some searches word aligned
		if ($urandom_range(1))
			req.idx = bfz_pkg::IDX_W'($urandom);
		else if (req.kind == bfz_pkg::OP_FIND && $urandom_range(2) == 0)
			req.idx = bfz_pkg::IDX_W'(hot_word() * WORD_W);
		else
			req.idx = bfz_pkg::IDX_W'(hot_word() * WORD_W + $urandom_range(WORD_W - 1));
		pick = $urandom_range(99);
		if (pick < 40)
			req.len = bfz_pkg::LEN_W'($urandom_range(64));
		else if (pick < 70)
			req.len = bfz_pkg::LEN_W'($urandom_range(300));
		else if (pick < 90)
			req.len = bfz_pkg::LEN_W'($urandom_range(MAP_BITS));
		else
			req.len = bfz_pkg::LEN_W'($urandom);
		return req;
	endfunction

	// offer one request at the falling edge and wait for its transfer
	task automatic deliver(input request_t req, input logic typed, input answer_t typed_ans);
		answer_t predicted;
		int      phase;
		@(negedge clk);
		// three idling phases over the run; the last one starts with a long hold-off
		phase = sent_count * 3 / TOTAL_ITEMS;
		if (phase != idle_phase) begin
			idle_phase = phase;
			case (phase)
				1: begin
					send_idle_pct = 45;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					stall_asked++;
				end
			endcase
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid      <= 1'b0;
			req_type      <= bfz_pkg::TYPE_W'($urandom);
			bit_index     <= bfz_pkg::IDX_W'($urandom);
			search_length <= bfz_pkg::LEN_W'($urandom);
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= req.kind;
		bit_index     <= req.idx;
		search_length <= req.len;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = bitmap_apply(req);
		predicted_answers.push_back(typed ? typed_ans : predicted);
		sent_count++;
	endtask

	// fill one word bit by bit, maybe leaving a hole, then search across it
	task automatic fill_and_search();
		int unsigned word;
		int unsigned hole;
		int          start;
		request_t    req;
		word = hot_word();
		hole = ($urandom_range(3) == 0) ? $urandom_range(WORD_W - 1) : WORD_W;
		for (int b = 0; b < WORD_W; b++) begin
			if (b != hole) begin
				req.kind = ($urandom_range(1)) ? bfz_pkg::OP_SET : bfz_pkg::OP_TAS;
				req.idx  = bfz_pkg::IDX_W'(word * WORD_W + b);
				req.len  = bfz_pkg::LEN_W'($urandom);
				deliver(req, 1'b0, '0);
			end
		end
		start = int'(word * WORD_W) - int'($urandom_range(40));
		if (start < 0)
			start = 0;
		req.kind = bfz_pkg::OP_FIND;
		req.idx  = bfz_pkg::IDX_W'(start);
		req.len  = bfz_pkg::LEN_W'($urandom_range(1, 160));
		deliver(req, 1'b0, '0);
	endtask

	// knock a few bits out of one hot word
	task automatic punch_holes();
		int unsigned word;
		request_t    req;
		word = hot_word();
		for (int n = 0; n < 8; n++) begin
			req.kind = ($urandom_range(1)) ? bfz_pkg::OP_CLR : bfz_pkg::OP_TAC;
			req.idx  = bfz_pkg::IDX_W'(word * WORD_W + $urandom_range(WORD_W - 1));
			req.len  = bfz_pkg::LEN_W'($urandom);
			deliver(req, 1'b0, '0);
		end
	endtask

	function automatic row_t row(input logic [2:0] kind, input int idx, input int len,
			input int typed, input int ob, input int fidx, input int fnd);
		row_t r;
		r.req.kind          = kind;
		r.req.idx           = bfz_pkg::IDX_W'(idx);
		r.req.len           = bfz_pkg::LEN_W'(len);
		r.typed             = (typed != 0);
		r.ans.old_bit       = (ob != 0);
		r.ans.found_index   = bfz_pkg::FIDX_W'(fidx);
		r.ans.found         = (fnd != 0);
		return r;
	endfunction

	// receiver: random ready at the falling edge, plus the long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_done != stall_asked) begin
				out_ready <= 1'b0;
				stall_done++;
				repeat (LONG_STALL - 1) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// result checker: every transfer against the oldest prediction
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_answers.size() == 0) begin
				$display("%0t: result transfer with nothing outstanding: %s %0d %0d %0d",
					$time, "old_bit found_index found", old_bit, found_index, found);
				error_count++;
			end else begin
				want = predicted_answers.pop_front();
				if (old_bit !== want.old_bit) begin
					$display("%0t: old_bit expected %0d got %0d", $time, want.old_bit, old_bit);
					error_count++;
				end
				if (found_index !== want.found_index) begin
					$display("%0t: found_index expected %0d got %0d",
						$time, want.found_index, found_index);
					error_count++;
				end
				if (found !== want.found) begin
					$display("%0t: found expected %0d got %0d", $time, want.found, found);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results outstanding",
				$time, predicted_answers.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = '0;
		bit_index     = '0;
		search_length = '0;
		error_count   = 0;
		cycle_count   = 0;
		sent_count    = 0;
		stall_asked   = 0;
		stall_done    = 0;
		idle_phase    = 0;
		send_idle_pct = 13;
		recv_idle_pct = 45;
		bit_op_count  = 0;
		search_count  = 0;
		search_hits   = 0;
		full_word_searches = 0;
		unused_count  = 0;
		foreach (map_words[w])
			map_words[w] = '0;

		// directed table: kind, index, length, typed, old_bit, found_index, found
		directed_rows.push_back(row(bfz_pkg::OP_TEST,     0,    0, 1, 0,    0, 0)); // fresh map
		directed_rows.push_back(row(bfz_pkg::OP_FIND,     0, 4096, 1, 0,    0, 1)); // first free
		directed_rows.push_back(row(bfz_pkg::OP_FIND,  4095,    0, 1, 0, 4095, 0)); // zero length
		directed_rows.push_back(row(bfz_pkg::OP_SET,      0,    0, 1, 0,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_SET,      0,    0, 1, 1,    0, 0)); // already set
		directed_rows.push_back(row(bfz_pkg::OP_TAS,   4095, 8191, 1, 0,    0, 0)); // last bit
		directed_rows.push_back(row(bfz_pkg::OP_TEST,  4095,    0, 1, 1,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_FIND,  4095, 8191, 1, 0, 4096, 0)); // clamped
		directed_rows.push_back(row(bfz_pkg::OP_FIND,     0,    1, 1, 0,    1, 0)); // miss
		directed_rows.push_back(row(bfz_pkg::OP_FIND,     0, 8191, 1, 0,    1, 1));
		directed_rows.push_back(row(bfz_pkg::OP_CLR,   4095,    0, 1, 1,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_TAC,      0,    0, 1, 1,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_TAC,      0,    0, 1, 0,    0, 0)); // already clear
		directed_rows.push_back(row(bfz_pkg::OP_CLR,   2730, 4096, 1, 0,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_TAS,   1365,    0, 1, 0,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_TAS,   1365,    0, 1, 1,    0, 0));
		directed_rows.push_back(row(OP_RSVD6,          4095, 8191, 1, 0,    0, 0)); // unused types
		directed_rows.push_back(row(OP_RSVD7,          1365, 4096, 1, 0,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_TEST,  1365, 8191, 0, 0,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_FIND,  1365,    2, 0, 0,    0, 0)); // set start
		directed_rows.push_back(row(bfz_pkg::OP_FIND,  1364,    1, 0, 0,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_SET,   2730,    0, 0, 0,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_FIND,  2730, 4096, 0, 0,    0, 0));
		directed_rows.push_back(row(bfz_pkg::OP_FIND,  4064,   32, 0, 0,    0, 0)); // last word

		// reset once, released at a falling edge; the block wipes its ram before taking requests
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			deliver(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].ans);

		// random part: word fills with searches across them, hole punching, single requests
		while (sent_count < TOTAL_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 12)
				fill_and_search();
			else if (pick < 16)
				punch_holes();
			else
				deliver(random_request(), 1'b0, '0);
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// let every outstanding result arrive, then watch for stray transfers
		while (predicted_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d transfers: %0d bit requests, %0d unused request types",
			sent_count, bit_op_count, unused_count);
		$display("searches: %0d, %0d hit a free bit, %0d ran across a fully set word",
			search_count, search_hits, full_word_searches);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
